@@ sv/desa_pkg.sv @@
// Shared types and constants for the double-ended stack allocator.
// No dependencies; imported by every module of the block.
package desa_pkg;

  localparam int unsigned MARKER_BYTES = 16;
  localparam int unsigned MAX_BLOCKS   = 64;
  localparam int unsigned DEPTH_W      = $clog2(MAX_BLOCKS + 1);
  localparam int unsigned ID_W         = 7;
  localparam int unsigned CMP_W        = (DEPTH_W > ID_W) ? DEPTH_W : ID_W;

  typedef enum logic [3:0] {
    ACT_ALLOC_LOW      = 4'd0,
    ACT_ALLOC_HIGH     = 4'd1,
    ACT_FREE_LOW       = 4'd2,
    ACT_FREE_HIGH      = 4'd3,
    ACT_FREE_LOW_TOP   = 4'd4,
    ACT_FREE_HIGH_TOP  = 4'd5,
    ACT_CLEAR_ALL      = 4'd6,
    ACT_CLEAR_LOW      = 4'd7,
    ACT_CLEAR_HIGH     = 4'd8
  } desa_action_e;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_OOM       = 3'd1,
    ST_FULL      = 3'd2,
    ST_BADMARK   = 3'd3,
    ST_BADALIGN  = 3'd4
  } desa_status_e;

  typedef struct packed {
    logic [3:0]      action;
    logic [31:0]     request_bytes;
    logic [7:0]      align_bytes;
    logic [ID_W-1:0] target_id;
  } desa_req_t;

  typedef struct packed {
    logic [2:0]      status;
    logic [63:0]     block_address;
    logic [ID_W-1:0] new_id;
    logic            freed;
    logic [31:0]     low_used;
    logic [31:0]     high_used;
    logic [31:0]     peak_used;
  } desa_res_t;

  // Shift control for one marker chain
  typedef struct packed {
    logic push;
    logic pop;
  } desa_shift_t;

endpackage

@@ sv/desa_cell.sv @@
// One marker cell: holds one saved byte count of a stack.
// Depends on desa_pkg for the shift control struct.
module desa_cell (
  input  logic                clk_i,
  input  desa_pkg::desa_shift_t ctrl_i,
  input  logic [31:0]         up_i,
  input  logic [31:0]         down_i,
  output logic [31:0]         value_o
);
  import desa_pkg::*;

  logic [31:0] value_q;

  // Push takes the entry above, pop takes the entry below
  always_ff @(posedge clk_i) begin
    if (ctrl_i.push) begin
      value_q <= up_i;
    end else if (ctrl_i.pop) begin
      value_q <= down_i;
    end
  end

  assign value_o = value_q;

endmodule

@@ sv/desa_chain.sv @@
// Marker stack built as a row of shifting cells; cell 0 is the top entry.
// Depends on desa_pkg and desa_cell.
module desa_chain (
  input  logic                  clk_i,
  input  desa_pkg::desa_shift_t ctrl_i,
  input  logic [31:0]           push_data_i,
  output logic [31:0]           top_o
);
  import desa_pkg::*;

  logic [31:0] cell_val [MAX_BLOCKS];

  for (genvar k = 0; k < MAX_BLOCKS; k++) begin : g_cell
    logic [31:0] up_val;
    logic [31:0] down_val;

    if (k == 0) begin : g_first
      assign up_val = push_data_i;
    end else begin : g_mid
      assign up_val = cell_val[k-1];
    end

    if (k == MAX_BLOCKS - 1) begin : g_last
      assign down_val = '0;
    end else begin : g_inner
      assign down_val = cell_val[k+1];
    end

    desa_cell u_cell (
      .clk_i   (clk_i),
      .ctrl_i  (ctrl_i),
      .up_i    (up_val),
      .down_i  (down_val),
      .value_o (cell_val[k])
    );
  end

  assign top_o = cell_val[0];

endmodule

@@ sv/double_ended_stack_allocator.sv @@
// Double-ended stack allocator: two marker chains plus the control sequencer.
// Depends on desa_pkg and desa_chain. A granted allocation passes S_EVAL, S_ADDR, S_ROUND and S_REPORT;
// a free or matched if_top free passes S_EVAL, then S_POP, one pop per cycle through the chain, then S_REPORT;
// free to target zero, bad marker, unmatched if_top and all other actions go from S_EVAL to S_REPORT.
// One transaction at a time; busy drops in the strobe cycle, so a new request waits for the result.
// Results cannot be stalled. Reset clears depths, byte counts, peak and registers only.
module double_ended_stack_allocator (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  desa_pkg::desa_req_t req_i,
  output logic                done_o,
  output desa_pkg::desa_res_t res_o,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [3:0]          paddr,
  input  logic [63:0]         pwdata,
  output logic [63:0]         prdata,
  output logic                pready
);
  import desa_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EVAL,
    S_POP,
    S_ADDR,
    S_ROUND,
    S_REPORT
  } state_e;

  state_e             state_q;
  desa_req_t          req_q;
  logic [63:0]        base_q;
  logic [31:0]        cap_q;
  logic [DEPTH_W-1:0] low_depth_q;
  logic [DEPTH_W-1:0] high_depth_q;
  logic [31:0]        low_bytes_q;
  logic [31:0]        high_bytes_q;
  logic [31:0]        peak_q;
  logic [2:0]         status_q;
  logic [63:0]        addr_q;
  logic [63:0]        off_q;
  logic [ID_W-1:0]    nid_q;
  logic               freed_q;
  logic               pop_high_q;
  logic               done_q;
  desa_res_t          res_q;

  // Configuration port
  logic cfg_wr;
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  assign prdata = paddr[3] ? {32'd0, cap_q} : base_q;

  // Request evaluation
  logic               sel_high;
  logic [DEPTH_W-1:0] cur_depth;
  logic [DEPTH_W-1:0] free_depth;
  logic [32:0]        used;
  logic [32:0]        avail;
  logic [32:0]        data_sz;
  logic [33:0]        block_sz;
  logic [34:0]        high_off;
  logic               bad_align;
  logic               oom;
  logic               full;
  logic               grant;
  logic [CMP_W-1:0]   tgt_c;
  logic [CMP_W-1:0]   fdep_c;
  logic [CMP_W-1:0]   pdep_c;
  logic [32:0]        peak_sum;
  logic [31:0]        peak_sat;
  logic [63:0]        al_mask;

  assign sel_high   = (req_q.action == ACT_ALLOC_HIGH);
  assign cur_depth  = sel_high ? high_depth_q : low_depth_q;
  assign free_depth = ((req_q.action == ACT_FREE_HIGH) ||
                       (req_q.action == ACT_FREE_HIGH_TOP)) ? high_depth_q : low_depth_q;
  assign used       = {1'b0, low_bytes_q} + {1'b0, high_bytes_q};
  assign avail      = (used > {1'b0, cap_q}) ? 33'd0 : ({1'b0, cap_q} - used);
  assign data_sz    = {1'b0, req_q.request_bytes} + 33'(req_q.align_bytes);
  assign block_sz   = {1'b0, data_sz} + 34'(MARKER_BYTES);
  assign high_off   = {3'd0, cap_q} - {3'd0, high_bytes_q} - {2'd0, data_sz};
  assign bad_align  = (req_q.align_bytes > 8'd1) &&
                      ((req_q.align_bytes & (req_q.align_bytes - 8'd1)) != 8'd0);
  assign oom        = block_sz > {1'b0, avail};
  assign full       = cur_depth >= DEPTH_W'(MAX_BLOCKS);
  assign grant      = !bad_align && !oom && !full;
  assign tgt_c      = CMP_W'(req_q.target_id);
  assign fdep_c     = CMP_W'(free_depth);
  assign pdep_c     = CMP_W'(pop_high_q ? high_depth_q : low_depth_q);
  assign peak_sum   = {1'b0, low_bytes_q} + {1'b0, high_bytes_q};
  assign peak_sat   = peak_sum[32] ? 32'hFFFF_FFFF : peak_sum[31:0];
  assign al_mask    = 64'(req_q.align_bytes - 8'd1);

  // Marker chains
  desa_shift_t low_ctrl;
  desa_shift_t high_ctrl;
  logic [31:0] low_top;
  logic [31:0] high_top;
  logic        is_alloc;

  assign is_alloc       = (req_q.action == ACT_ALLOC_LOW) || (req_q.action == ACT_ALLOC_HIGH);
  assign low_ctrl.push  = (state_q == S_EVAL) && is_alloc && grant && !sel_high;
  assign high_ctrl.push = (state_q == S_EVAL) && is_alloc && grant && sel_high;
  assign low_ctrl.pop   = (state_q == S_POP) && !pop_high_q;
  assign high_ctrl.pop  = (state_q == S_POP) && pop_high_q;

  desa_chain u_low_chain (
    .clk_i       (clk_i),
    .ctrl_i      (low_ctrl),
    .push_data_i (low_bytes_q),
    .top_o       (low_top)
  );

  desa_chain u_high_chain (
    .clk_i       (clk_i),
    .ctrl_i      (high_ctrl),
    .push_data_i (high_bytes_q),
    .top_o       (high_top)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      req_q        <= '0;
      base_q       <= '0;
      cap_q        <= '0;
      low_depth_q  <= '0;
      high_depth_q <= '0;
      low_bytes_q  <= '0;
      high_bytes_q <= '0;
      peak_q       <= '0;
      status_q     <= ST_OK;
      addr_q       <= '0;
      off_q        <= '0;
      nid_q        <= '0;
      freed_q      <= 1'b0;
      pop_high_q   <= 1'b0;
      done_q       <= 1'b0;
      res_q        <= '0;
    end else begin
      done_q <= 1'b0;

      if (cfg_wr) begin
        if (paddr[3]) begin
          cap_q <= pwdata[31:0];
        end else begin
          base_q <= pwdata;
        end
      end

      case (state_q)
        S_IDLE: begin
          if (start) begin
            req_q    <= req_i;
            status_q <= ST_OK;
            addr_q   <= '0;
            nid_q    <= '0;
            freed_q  <= 1'b0;
            state_q  <= S_EVAL;
          end
        end

        S_EVAL: begin
          state_q <= S_REPORT;
          case (req_q.action)
            ACT_ALLOC_LOW, ACT_ALLOC_HIGH: begin
              if (bad_align) begin
                status_q <= ST_BADALIGN;
              end else if (oom) begin
                status_q <= ST_OOM;
              end else if (full) begin
                status_q <= ST_FULL;
              end else begin
                nid_q <= ID_W'(cur_depth + DEPTH_W'(1));
                if (sel_high) begin
                  high_depth_q <= high_depth_q + DEPTH_W'(1);
                  high_bytes_q <= high_bytes_q + block_sz[31:0];
                  off_q        <= {{29{high_off[34]}}, high_off};
                end else begin
                  low_depth_q <= low_depth_q + DEPTH_W'(1);
                  low_bytes_q <= low_bytes_q + block_sz[31:0];
                  off_q       <= {32'd0, low_bytes_q};
                end
                state_q <= S_ADDR;
              end
            end
            ACT_FREE_LOW, ACT_FREE_HIGH: begin
              pop_high_q <= (req_q.action == ACT_FREE_HIGH);
              if (tgt_c > fdep_c) begin
                status_q <= ST_BADMARK;
              end else if (tgt_c == '0) begin
                // Target zero empties the whole end
                if (req_q.action == ACT_FREE_HIGH) begin
                  high_depth_q <= '0;
                  high_bytes_q <= '0;
                end else begin
                  low_depth_q <= '0;
                  low_bytes_q <= '0;
                end
              end else begin
                state_q <= S_POP;
              end
            end
            ACT_FREE_LOW_TOP, ACT_FREE_HIGH_TOP: begin
              pop_high_q <= (req_q.action == ACT_FREE_HIGH_TOP);
              if ((fdep_c != '0) && (tgt_c == fdep_c)) begin
                freed_q <= 1'b1;
                state_q <= S_POP;
              end
            end
            ACT_CLEAR_ALL: begin
              low_depth_q  <= '0;
              low_bytes_q  <= '0;
              high_depth_q <= '0;
              high_bytes_q <= '0;
            end
            ACT_CLEAR_LOW: begin
              low_depth_q <= '0;
              low_bytes_q <= '0;
            end
            ACT_CLEAR_HIGH: begin
              high_depth_q <= '0;
              high_bytes_q <= '0;
            end
            default: begin
              status_q <= ST_OK;
            end
          endcase
        end

        // Pop one marker per cycle until the target marker is gone
        S_POP: begin
          if (pop_high_q) begin
            high_bytes_q <= high_top;
            high_depth_q <= high_depth_q - DEPTH_W'(1);
          end else begin
            low_bytes_q <= low_top;
            low_depth_q <= low_depth_q - DEPTH_W'(1);
          end
          if (pdep_c == tgt_c) begin
            state_q <= S_REPORT;
          end
        end

        S_ADDR: begin
          addr_q <= base_q + off_q;
          if (peak_sat > peak_q) begin
            peak_q <= peak_sat;
          end
          state_q <= S_ROUND;
        end

        S_ROUND: begin
          if (req_q.align_bytes > 8'd1) begin
            addr_q <= (addr_q + al_mask) & ~al_mask;
          end
          state_q <= S_REPORT;
        end

        S_REPORT: begin
          res_q.status        <= status_q;
          res_q.block_address <= addr_q;
          res_q.new_id        <= nid_q;
          res_q.freed         <= freed_q;
          res_q.low_used      <= low_bytes_q;
          res_q.high_used     <= high_bytes_q;
          res_q.peak_used     <= peak_q;
          done_q              <= 1'b1;
          state_q             <= S_IDLE;
        end

        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign busy   = (state_q != S_IDLE);
  assign done_o = done_q;
  assign res_o  = res_q;

endmodule
